// ===== src/wao_pkg.sv =====
// shared types, constants and helpers of the weighted absolute overlap accumulator
package wao_pkg;

    localparam int MAX_ORBITALS = 8;
    localparam int IDX_W        = $clog2(MAX_ORBITALS);
    localparam int CNT_W        = 4;
    localparam int TRI_DEPTH    = (MAX_ORBITALS * (MAX_ORBITALS + 1)) / 2;
    localparam int SLOT_W       = $clog2(TRI_DEPTH);
    localparam int VAL_W        = 16;
    localparam int WGT_W        = 16;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int TERM_W       = PROD_W + WGT_W;
    localparam int ACC_W        = 64;
    localparam int CMDQ_DEPTH   = 2;
    localparam int RESQ_DEPTH   = 4;

    // request codes of an input item
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] grid_value;
        logic [WGT_W-1:0]        point_weight;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [ACC_W-1:0] overlap_value;
        logic             last_entry;
    } t_result;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] pos;
        logic [VAL_W-1:0] value;
        logic [WGT_W-1:0] weight;
    } t_cmd;

    // matrix dimension in use: zero counts as one, large values clip
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] n;
        n = raw;
        if (n == '0) begin
            n = CNT_W'(1);
        end
        if (n > CNT_W'(MAX_ORBITALS)) begin
            n = CNT_W'(MAX_ORBITALS);
        end
        return n;
    endfunction

    // packed lower triangle slot of entry (hi, lo) with lo <= hi
    function automatic logic [SLOT_W-1:0] tri_slot(input logic [IDX_W-1:0] hi,
                                                   input logic [IDX_W-1:0] lo);
        logic [SLOT_W+IDX_W:0] prod;
        prod = (SLOT_W+IDX_W+1)'(hi) * ((SLOT_W+IDX_W+1)'(hi) + (SLOT_W+IDX_W+1)'(1));
        return SLOT_W'(prod >> 1) + SLOT_W'(lo);
    endfunction

    // magnitude of a signed sample as unsigned
    function automatic logic [VAL_W-1:0] abs_val(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
    endfunction

endpackage

// ===== src/weighted_abs_overlap_accumulator.sv =====
// top level of the weighted absolute overlap accumulator
// Accumulates S[i][j] += w * |p_i * p_j| over grid points into 64-bit saturating
// accumulators (units 2^-40) kept as a packed lower triangle. A sample item of
// position p is loaded in the back end, then makes p + 1 issues of the single
// shared multiply-accumulate pipeline (one stored value per cycle), then waits for
// that pipeline to drain. A read emits n*n results row-major, one per cycle while
// the result queue has room. A two-entry command queue lets the front keep
// accepting items while the back end works. No clearing pass is needed after reset.
module weighted_abs_overlap_accumulator import wao_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item input
    input  logic             push,
    input  t_item            i_item,
    output logic             full,
    // result output
    output logic             empty,
    input  logic             pop,
    output t_result          o_result,
    // configuration: orbital count
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0] r_orbital_count;
    logic [CNT_W-1:0] count_eff;
    logic             cmd_valid;
    logic             cmd_pop;
    t_cmd             cmd;

    // config transfer accepted every cycle
    assign o_cfg_ready = 1'b1;
    assign count_eff   = eff_count(r_orbital_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbital_count <= CNT_W'(MAX_ORBITALS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_orbital_count <= i_cfg_data;
        end
    end

    // classify items, track position and weight
    wao_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_count     (count_eff),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // accumulate, read out, queue results
    wao_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count     (count_eff),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

// ===== src/wao_front.sv =====
// front end: takes items, tracks position in the point and latches weights
module wao_front import wao_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_item            i_item,
    output logic             o_full,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_pop
);

    localparam int QP_W = $clog2(CMDQ_DEPTH);
    localparam int QC_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_q [CMDQ_DEPTH];
    logic [QP_W-1:0]  r_wptr;
    logic [QP_W-1:0]  r_rptr;
    logic [QC_W-1:0]  r_cnt;
    logic [IDX_W-1:0] r_pos;
    logic [WGT_W-1:0] r_weight;

    logic             accept;
    logic             do_push;
    logic             do_pop;
    logic [IDX_W-1:0] pos_eff;
    logic [CNT_W-1:0] pos_inc;
    logic [WGT_W-1:0] weight_use;
    t_cmd             cmd;
    logic [IDX_W-1:0] n_pos;
    logic [WGT_W-1:0] n_weight;

    assign o_full      = (r_cnt == QC_W'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rptr];
    assign accept      = i_push && !o_full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    // lowered count in mid-point restarts at position zero
    assign pos_eff    = ({1'b0, r_pos} >= i_count) ? '0 : r_pos;
    assign pos_inc    = {1'b0, pos_eff} + CNT_W'(1);
    assign weight_use = (pos_eff == '0) ? i_item.point_weight : r_weight;

    always_comb begin
        cmd.kind   = CMD_SAMPLE;
        cmd.pos    = pos_eff;
        cmd.value  = i_item.grid_value;
        cmd.weight = weight_use;
        do_push    = 1'b0;
        n_pos      = r_pos;
        n_weight   = r_weight;
        case (i_item.req_type)
            REQ_SAMPLE: begin
                do_push  = accept;
                n_pos    = (pos_inc >= i_count) ? '0 : pos_inc[IDX_W-1:0];
                n_weight = weight_use;
            end
            REQ_READ: begin
                cmd.kind = CMD_READ;
                do_push  = accept;
                n_pos    = '0;
            end
            REQ_CLEAR: begin
                cmd.kind = CMD_CLEAR;
                do_push  = accept;
                n_pos    = '0;
            end
            default: begin
                do_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_weight <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_cnt    <= '0;
        end else begin
            if (accept) begin
                r_pos    <= n_pos;
                r_weight <= n_weight;
            end
            if (do_push) begin
                r_wptr <= r_wptr + QP_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QP_W'(1);
            end
            r_cnt <= r_cnt + QC_W'(do_push) - QC_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= cmd;
        end
    end

endmodule

// ===== src/wao_back.sv =====
// back end: multiply-accumulate over the point, matrix read-out and result queue
module wao_back import wao_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output t_result          o_result
);

    localparam int RP_W = $clog2(RESQ_DEPTH);
    localparam int RC_W = $clog2(RESQ_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_READ  = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;

    logic [VAL_W-1:0] r_pv [MAX_ORBITALS];
    logic [ACC_W-1:0] r_acc_mem [TRI_DEPTH];
    logic [TRI_DEPTH-1:0] r_valid;

    logic [VAL_W-1:0] r_ai;
    logic [WGT_W-1:0] r_w;
    logic [IDX_W-1:0] r_pos;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_r;
    logic [IDX_W-1:0] r_c;

    // shared accumulator read port
    logic [ACC_W-1:0] r_rd;
    logic             r_rd_ok;

    // mac pipeline
    logic              r_p1_vld;
    logic [PROD_W-1:0] r_p1;
    logic [SLOT_W-1:0] r_p1_slot;
    logic              r_s2_vld;
    logic [TERM_W-1:0] r_term;
    logic [ACC_W-1:0]  r_acc;
    logic [SLOT_W-1:0] r_s2_slot;

    // read-out pipeline
    logic             r_rq_vld;
    logic [IDX_W-1:0] r_rq_row;
    logic [IDX_W-1:0] r_rq_col;
    logic             r_rq_last;

    // result queue
    t_result          r_resq [RESQ_DEPTH];
    logic [RP_W-1:0]  r_res_wptr;
    logic [RP_W-1:0]  r_res_rptr;
    logic [RC_W-1:0]  r_res_cnt;

    logic             mac_issue;
    logic             rd_issue;
    logic             room;
    logic             res_pop;
    logic [IDX_W-1:0] nm1;
    logic             rd_last;
    logic [IDX_W-1:0] rd_hi;
    logic [IDX_W-1:0] rd_lo;
    logic [SLOT_W-1:0] rd_slot;
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] sum_sat;
    t_result          res_in;

    assign nm1       = IDX_W'(i_count - CNT_W'(1));
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign mac_issue = (r_state == ST_MAC);
    assign room      = ({1'b0, r_res_cnt} + (RC_W+1)'(r_rq_vld)) < (RC_W+1)'(RESQ_DEPTH);
    assign rd_issue  = (r_state == ST_READ) && room;
    assign rd_last   = (r_r == nm1) && (r_c == nm1);
    assign rd_hi     = (r_r > r_c) ? r_r : r_c;
    assign rd_lo     = (r_r > r_c) ? r_c : r_r;
    assign rd_slot   = mac_issue ? tri_slot(r_pos, r_j) : tri_slot(rd_hi, rd_lo);

    assign sum     = {1'b0, r_acc} + (ACC_W+1)'(r_term);
    assign sum_sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

    assign res_in.row_index     = r_rq_row;
    assign res_in.col_index     = r_rq_col;
    assign res_in.overlap_value = r_rd_ok ? r_rd : '0;
    assign res_in.last_entry    = r_rq_last;

    assign o_empty  = (r_res_cnt == '0);
    assign o_result = r_resq[r_res_rptr];
    assign res_pop  = i_pop && !o_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        CMD_SAMPLE: n_state = ST_MAC;
                        CMD_READ:   n_state = ST_READ;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MAC: begin
                if (r_j == r_pos) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_READ: begin
                if (rd_issue && rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_p1_vld && !r_s2_vld && !r_rq_vld) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_j        <= '0;
            r_r        <= '0;
            r_c        <= '0;
            r_p1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_rq_vld   <= 1'b0;
            r_res_wptr <= '0;
            r_res_rptr <= '0;
            r_res_cnt  <= '0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= mac_issue;
            r_s2_vld <= r_p1_vld;
            r_rq_vld <= rd_issue;
            if (o_cmd_pop) begin
                r_j <= '0;
                r_r <= '0;
                r_c <= '0;
                if (i_cmd.kind == CMD_CLEAR) begin
                    r_valid <= '0;
                end
            end
            if (mac_issue) begin
                r_j <= r_j + IDX_W'(1);
            end
            if (rd_issue) begin
                if (r_c == nm1) begin
                    r_c <= '0;
                    r_r <= r_r + IDX_W'(1);
                end else begin
                    r_c <= r_c + IDX_W'(1);
                end
            end
            if (r_s2_vld) begin
                r_valid[r_s2_slot] <= 1'b1;
            end
            if (r_rq_vld) begin
                r_res_wptr <= r_res_wptr + RP_W'(1);
            end
            if (res_pop) begin
                r_res_rptr <= r_res_rptr + RP_W'(1);
            end
            r_res_cnt <= r_res_cnt + RC_W'(r_rq_vld) - RC_W'(res_pop);
        end
    end

    // payload registers and memories
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd.kind == CMD_SAMPLE)) begin
            r_pv[i_cmd.pos] <= i_cmd.value;
            r_ai            <= abs_val(i_cmd.value);
            r_w             <= i_cmd.weight;
            r_pos           <= i_cmd.pos;
        end
        r_rd      <= r_acc_mem[rd_slot];
        r_rd_ok   <= r_valid[rd_slot];
        r_p1      <= PROD_W'(r_ai) * PROD_W'(abs_val(r_pv[r_j]));
        r_p1_slot <= rd_slot;
        r_term    <= TERM_W'(r_p1) * TERM_W'(r_w);
        r_acc     <= r_rd_ok ? r_rd : '0;
        r_s2_slot <= r_p1_slot;
        r_rq_row  <= r_r;
        r_rq_col  <= r_c;
        r_rq_last <= rd_last;
        if (r_s2_vld) begin
            r_acc_mem[r_s2_slot] <= sum_sat;
        end
        if (r_rq_vld) begin
            r_resq[r_res_wptr] <= res_in;
        end
    end

    a_resq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rq_vld |-> (r_res_cnt < RC_W'(RESQ_DEPTH)))
        else $error("result queue overflow");

    a_mac_in_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_j <= r_pos))
        else $error("mac index past point position");

    a_write_in_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_state == ST_MAC || r_state == ST_DRAIN))
        else $error("accumulator write outside a sample");

endmodule
